// ===== rtl/avo_pkg.sv =====
// Shared types and constants for the atom volume overlap block.
// No dependencies; the front, back, top level and testbench import this package.
package avo_pkg;

   // Field widths fixed by the interface.
   localparam int LEN_W = 16;
   localparam int VOL_W = 32;
   localparam int ACC_W = 40;

   // 4*pi/3 and pi, both scaled by 2^K_BITS.
   localparam int K_BITS    = 14;
   localparam int SPHERE_KW = 17;
   localparam int PI_KW     = 16;
   localparam logic [SPHERE_KW-1:0] SPHERE_K = 17'd68629;
   localparam logic [PI_KW-1:0]     PI_K     = 16'd51472;

   // Cap denominator is 12 times the distance.
   localparam int DEN_W = LEN_W + 4;
   localparam logic [DEN_W-1:0] DEN_MUL = 20'd12;

   // Largest cap magnitude and output saturation value.
   localparam logic [ACC_W:0]   CAP_CLAMP = 41'h100_0000_0000;
   localparam logic [VOL_W-1:0] OUT_MAX   = 32'hFFFF_FFFF;

   // One classified request as it travels from front to back.
   typedef struct packed {
      logic             first;
      logic             last;
      logic             skip;
      logic [LEN_W-1:0] ra;
      logic [LEN_W-1:0] rmin;
      logic [LEN_W-1:0] rb;
      logic [LEN_W-1:0] distance;
   } item_type;

endpackage

// ===== rtl/avo_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; no package dependency.
module avo_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Storage is written without reset; only the pointers and the fill count are cleared.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointer and fill count bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/avo_front.sv =====
// Front end: accepts requests, tracks the atom radius and marks skipped neighbors.
// Depends on avo_pkg.
module avo_front
   import avo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             first_of_atom,
   input  logic             last_of_atom,
   input  logic             neighbour_valid,
   input  logic [LEN_W-1:0] atom_max_radius,
   input  logic [LEN_W-1:0] atom_min_radius,
   input  logic [LEN_W-1:0] neighbour_radius,
   input  logic [LEN_W-1:0] neighbour_distance,
   output item_type         item
);

   logic [LEN_W-1:0] held_ff, held_in;
   logic [LEN_W-1:0] ra;
   logic [LEN_W:0]   sum_r;

   // The first request of an atom brings its own radius.
   assign ra      = first_of_atom ? atom_max_radius : held_ff;
   assign held_in = (accept && first_of_atom) ? atom_max_radius : held_ff;
   assign sum_r   = {1'b0, ra} + {1'b0, neighbour_radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // An invalid neighbor, or one with no overlap or at zero distance, adds nothing.
   always_comb begin
      item.first    = first_of_atom;
      item.last     = last_of_atom;
      item.skip     = !neighbour_valid || (neighbour_distance == '0) ||
                      ({1'b0, neighbour_distance} >= sum_r);
      item.ra       = ra;
      item.rmin     = atom_min_radius;
      item.rb       = neighbour_radius;
      item.distance = neighbour_distance;
   end

endmodule

// ===== rtl/avo_back.sv =====
// Back end: sphere volumes, lens cap arithmetic, serial divider and accumulator.
// Depends on avo_pkg; takes classified requests from the queue.
module avo_back
   import avo_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  item_type         q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_taken,
   output logic [VOL_W-1:0] rsp_volume
);

   localparam int F     = FRAC_BITS;
   localparam int W_T   = 3 * LEN_W - F;
   localparam int W_SP  = W_T + SPHERE_KW + 1;
   localparam int W_V   = W_SP - F - K_BITS;
   localparam int W_HH  = 2 * (LEN_W + 1);
   localparam int W_H2  = W_HH - F;
   localparam int W_P   = 2 * LEN_W + 5;
   localparam int W_ABS = W_P - 1;
   localparam int W_M   = W_ABS - F;
   localparam int W_N   = W_H2 + W_M;
   localparam int W_NH  = W_N / 2;
   localparam int W_NK  = W_N + PI_KW;
   localparam int W_X   = W_NK + 1;
   localparam int W_CNT = $clog2(W_NK);
   localparam int W_SUM = ACC_W + 2;
   localparam logic signed [W_SUM-1:0] SUM_MAX = 42'sh07F_FFFF_FFFF;
   localparam logic signed [W_SUM-1:0] SUM_MIN = -42'sh080_0000_0000;

   typedef enum logic [3:0] {
      S_IDLE, S_SPH_SQ, S_SPH_CU, S_SPH_VOL, S_CHECK,
      S_CAP_H, S_CAP_DD, S_CAP_DS, S_CAP_Q, S_CAP_M, S_CAP_N,
      S_CAP_K0, S_CAP_K1, S_DIV, S_FIN, S_EMIT
   } state_type;

   state_type               state_ff;
   item_type                entry_ff;
   logic                    sel_ff;
   logic [2*LEN_W-1:0]      sq_ff;
   logic [W_T-1:0]          t_ff;
   logic [W_HH-1:0]         hh_ff;
   logic [2*LEN_W-1:0]      dd_ff;
   logic [2*LEN_W:0]        ds_ff;
   logic [2*LEN_W-1:0]      qq_ff;
   logic [W_M-1:0]          m_ff;
   logic                    neg_ff;
   logic [W_N-1:0]          n_ff;
   logic [W_NK-1:0]         nk_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [W_CNT-1:0]        cnt_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [VOL_W-1:0]        floor_ff;
   logic                    out_valid_ff;
   logic [VOL_W-1:0]        out_data_ff;

   logic [LEN_W-1:0]        r_sel;
   logic [2*LEN_W-1:0]      sq_in;
   logic [3*LEN_W-1:0]      cube_w;
   logic [W_SP-1:0]         sp_w;
   logic [ACC_W-1:0]        vol_in;
   logic [VOL_W-1:0]        floor_in;
   logic [LEN_W:0]          s_w, h_w;
   logic [LEN_W-1:0]        diff_w;
   logic [W_HH-1:0]         hh_in;
   logic [2*LEN_W-1:0]      dd_in, qq_in;
   logic [2*LEN_W:0]        ds_in;
   logic [W_P-1:0]          p_w, abs_w;
   logic [W_N-1:0]          n_in;
   logic [W_NK-1:0]         nk_lo, nk_hi;
   logic [DEN_W-1:0]        den_in;
   logic [DEN_W:0]          trial_w;
   logic                    ge_w;
   logic [DEN_W-1:0]        rem_in;
   logic [W_X-1:0]          x_w;
   logic [ACC_W:0]          cap_w;
   logic signed [W_SUM-1:0] sum_w;
   logic signed [ACC_W-1:0] acc_in;
   logic                    above_floor;
   logic [VOL_W-1:0]        result_w;

   assign q_pop      = (state_ff == S_IDLE) && !q_empty;
   assign rsp_valid  = out_valid_ff;
   assign rsp_volume = out_data_ff;

   // Sphere volume: r*r, then times r, then times 4*pi/3 with rounding.
   always_comb begin
      r_sel    = sel_ff ? entry_ff.rmin : entry_ff.ra;
      sq_in    = (2*LEN_W)'(r_sel) * (2*LEN_W)'(r_sel);
      cube_w   = (3*LEN_W)'(sq_ff) * (3*LEN_W)'(r_sel);
      sp_w     = W_SP'(t_ff) * W_SP'(SPHERE_K) + (W_SP'(1) << (F + K_BITS - 1));
      vol_in   = ACC_W'(sp_w[W_SP-1:F+K_BITS]);
      floor_in = (vol_in > ACC_W'(OUT_MAX)) ? OUT_MAX : vol_in[VOL_W-1:0];
   end

   // Cap operands: cap height, distance products, the radius difference, the numerator times pi and the denominator.
   always_comb begin
      s_w    = {1'b0, entry_ff.ra} + {1'b0, entry_ff.rb};
      h_w    = s_w - {1'b0, entry_ff.distance};
      diff_w = (entry_ff.ra >= entry_ff.rb) ? entry_ff.ra - entry_ff.rb
                                            : entry_ff.rb - entry_ff.ra;
      hh_in  = W_HH'(h_w) * W_HH'(h_w);
      dd_in  = (2*LEN_W)'(entry_ff.distance) * (2*LEN_W)'(entry_ff.distance);
      ds_in  = (2*LEN_W+1)'(entry_ff.distance) * (2*LEN_W+1)'(s_w);
      qq_in  = (2*LEN_W)'(diff_w) * (2*LEN_W)'(diff_w);
      p_w    = W_P'(dd_ff) + (W_P'(ds_ff) << 1) - W_P'(qq_ff) * W_P'(3);
      abs_w  = p_w[W_P-1] ? (~p_w + 1'b1) : p_w;
      n_in   = W_N'(hh_ff[W_HH-1:F]) * W_N'(m_ff);
      nk_lo  = W_NK'(n_ff[W_NH-1:0]) * W_NK'(PI_K);
      nk_hi  = (W_NK'(n_ff[W_N-1:W_NH]) * W_NK'(PI_K)) << W_NH;
      den_in = DEN_W'(entry_ff.distance) * DEN_MUL;
   end

   // One restoring division step per cycle.
   always_comb begin
      trial_w = {rem_ff, nk_ff[W_NK-1]};
      ge_w    = (trial_w >= {1'b0, den_ff});
      rem_in  = ge_w ? DEN_W'(trial_w - {1'b0, den_ff}) : trial_w[DEN_W-1:0];
   end

   // Rounded, clamped cap applied to the saturating accumulator.
   always_comb begin
      x_w    = W_X'(nk_ff) + (W_X'(1) << (K_BITS - 1));
      x_w    = x_w >> K_BITS;
      cap_w  = (x_w > W_X'(CAP_CLAMP)) ? CAP_CLAMP : x_w[ACC_W:0];
      if (neg_ff) begin
         sum_w = W_SUM'(acc_ff) + $signed(W_SUM'(cap_w));
      end else begin
         sum_w = W_SUM'(acc_ff) - $signed(W_SUM'(cap_w));
      end
      if (sum_w > SUM_MAX) begin
         acc_in = SUM_MAX[ACC_W-1:0];
      end else if (sum_w < SUM_MIN) begin
         acc_in = SUM_MIN[ACC_W-1:0];
      end else begin
         acc_in = sum_w[ACC_W-1:0];
      end
   end

   // Result is the larger of running volume and floor, saturated.
   always_comb begin
      above_floor = (acc_ff > $signed({{(ACC_W-VOL_W){1'b0}}, floor_ff}));
      if (!above_floor) begin
         result_w = floor_ff;
      end else if (acc_ff[ACC_W-1:VOL_W] != '0) begin
         result_w = OUT_MAX;
      end else begin
         result_w = acc_ff[VOL_W-1:0];
      end
   end

   // Sequencer for one request at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         floor_ff     <= '0;
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (out_valid_ff && rsp_taken) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  entry_ff <= q_data;
                  sel_ff   <= 1'b0;
                  state_ff <= q_data.first ? S_SPH_SQ : S_CHECK;
               end
            end
            S_SPH_SQ: begin
               sq_ff    <= sq_in;
               state_ff <= S_SPH_CU;
            end
            S_SPH_CU: begin
               t_ff     <= cube_w[3*LEN_W-1:F];
               state_ff <= S_SPH_VOL;
            end
            S_SPH_VOL: begin
               if (!sel_ff) begin
                  acc_ff   <= $signed(vol_in);
                  sel_ff   <= 1'b1;
                  state_ff <= S_SPH_SQ;
               end else begin
                  floor_ff <= floor_in;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (!entry_ff.skip && above_floor) begin
                  state_ff <= S_CAP_H;
               end else begin
                  state_ff <= entry_ff.last ? S_EMIT : S_IDLE;
               end
            end
            S_CAP_H: begin
               hh_ff    <= hh_in;
               state_ff <= S_CAP_DD;
            end
            S_CAP_DD: begin
               dd_ff    <= dd_in;
               state_ff <= S_CAP_DS;
            end
            S_CAP_DS: begin
               ds_ff    <= ds_in;
               state_ff <= S_CAP_Q;
            end
            S_CAP_Q: begin
               qq_ff    <= qq_in;
               state_ff <= S_CAP_M;
            end
            S_CAP_M: begin
               neg_ff   <= p_w[W_P-1];
               m_ff     <= abs_w[W_ABS-1:F];
               state_ff <= S_CAP_N;
            end
            S_CAP_N: begin
               n_ff     <= n_in;
               state_ff <= S_CAP_K0;
            end
            S_CAP_K0: begin
               nk_ff    <= nk_lo;
               state_ff <= S_CAP_K1;
            end
            S_CAP_K1: begin
               nk_ff    <= nk_ff + nk_hi;
               den_ff   <= den_in;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= rem_in;
               nk_ff  <= {nk_ff[W_NK-2:0], ge_w};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == W_CNT'(W_NK - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               acc_ff   <= acc_in;
               state_ff <= entry_ff.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!out_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= result_w;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // The partial remainder always stays below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the divisor");

   // A result appears only from the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside the emit step");

   // The running volume moves only on a sphere load or a cap update.
   a_acc_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(acc_ff) |-> ($past(reset) || $past(state_ff == S_SPH_VOL) ||
                            $past(state_ff == S_FIN)))
      else $error("accumulator changed outside an update step");
`endif

endmodule

// ===== rtl/atom_volume_overlap.sv =====
// Top level of the atom volume overlap block: front, queue and back.
// Depends on avo_pkg, avo_front, avo_fifo and avo_back.
//
// Usage: send one request per bonded neighbor of an atom, first_of_atom on
// the first and last_of_atom on the last; an atom without bonds sends one
// request with neighbour_valid low. A request is taken when push is high and
// full is low. After the last request of an atom one volume appears on
// rsp_volume while empty is low, and leaves when pop is high.
// Flow: the back end works on one request at a time. A skipped neighbor
// leaves the queue and then passes the overlap check. A first request also
// computes the two sphere volumes. An overlapping neighbor runs the cap
// states and then the one-bit-per-cycle divider for the cap, whose dividend
// is W_NK = 86 - 2*FRAC_BITS bits wide. A last request ends with the emit step.
// A queue of QUEUE_DEPTH requests lets the front keep accepting while the
// back computes, and a result register holds the volume while the receiver
// stalls; the back waits only when it has a new result and that register is
// still full. Reset empties the queue, drops the result valid flag and clears the atom state to zero.
module atom_volume_overlap
   import avo_pkg::*;
#(
   parameter int FRAC_BITS   = 12,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_first_of_atom,
   input  logic             req_last_of_atom,
   input  logic             req_neighbour_valid,
   input  logic [LEN_W-1:0] req_atom_max_radius,
   input  logic [LEN_W-1:0] req_atom_min_radius,
   input  logic [LEN_W-1:0] req_neighbour_radius,
   input  logic [LEN_W-1:0] req_neighbour_distance,
   output logic             empty,
   input  logic             pop,
   output logic [VOL_W-1:0] rsp_volume
);

   item_type front_item, queue_item;
   logic     accept, q_full, q_empty, q_pop, rsp_valid;

   assign accept = push && !q_full;
   assign full   = q_full;
   assign empty  = !rsp_valid;

   // Classify requests and track the atom radius.
   avo_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .first_of_atom      (req_first_of_atom),
      .last_of_atom       (req_last_of_atom),
      .neighbour_valid    (req_neighbour_valid),
      .atom_max_radius    (req_atom_max_radius),
      .atom_min_radius    (req_atom_min_radius),
      .neighbour_radius   (req_neighbour_radius),
      .neighbour_distance (req_neighbour_distance),
      .item               (front_item)
   );

   // Decoupling queue between front and back.
   avo_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (queue_item),
      .empty     (q_empty)
   );

   // Arithmetic and result register.
   avo_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (queue_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_taken  (pop),
      .rsp_volume (rsp_volume)
   );

endmodule

// ===== dv/atom_volume_overlap_test.sv =====
// Testbench for atom_volume_overlap: directed and random atoms, with a
// built-in predictor of the cap-overlap volume. Depends on avo_pkg and the RTL.
`timescale 1ns / 1ps

module atom_volume_overlap_test;
   import avo_pkg::*;

   localparam int FRAC = 12;

   typedef struct {
      bit             first;
      bit             last;
      bit             valid;
      bit             pause;
      bit [LEN_W-1:0] rmax;
      bit [LEN_W-1:0] rmin;
      bit [LEN_W-1:0] rb;
      bit [LEN_W-1:0] distance;
   } atom_req_type;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   logic             req_first_of_atom;
   logic             req_last_of_atom;
   logic             req_neighbour_valid;
   logic [LEN_W-1:0] req_atom_max_radius;
   logic [LEN_W-1:0] req_atom_min_radius;
   logic [LEN_W-1:0] req_neighbour_radius;
   logic [LEN_W-1:0] req_neighbour_distance;
   logic             empty;
   logic             pop;
   logic [VOL_W-1:0] rsp_volume;

   atom_req_type   pending_reqs[$];
   bit [VOL_W-1:0] volume_queue[$];
   atom_req_type   cur_req;
   int             errors = 0;
   int             accepted_reqs = 0;
   int             checked_volumes = 0;
   int             atom_count = 0;
   bit             quiet = 0;
   int             push_gap = 0;
   int             pop_gap = 0;

   // Predictor state of the running atom.
   longint         run_volume = 0;
   longint         floor_vol = 0;
   bit [LEN_W-1:0] held_radius = 0;

   atom_volume_overlap i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp40(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
   endfunction

   function automatic longint unsigned sphere_vol(longint unsigned r);
      longint unsigned t;
      t = (r * r * r) >> FRAC;
      return (t * 68629 + (64'd1 << (FRAC + 13))) >> (FRAC + 14);
   endfunction

   // Update the atom state with one request; report the volume if it is emitted.
   task automatic predict_volume(input atom_req_type q, output bit emits,
                                 output bit [VOL_W-1:0] vol);
      longint unsigned f, s, d, h, h2, m, n, den, a, r, x, cap;
      longint          p, diff;
      bit              neg;
      emits = 0;
      vol = 0;
      if (q.first) begin
         held_radius = q.rmax;
         run_volume = clamp40(longint'(sphere_vol(64'(q.rmax))));
         f = sphere_vol(64'(q.rmin));
         floor_vol = (f > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(f);
      end
      if (q.valid && run_volume > floor_vol) begin
         s = longint'(held_radius) + longint'(q.rb);
         d = 64'(q.distance);
         if (d != 0 && d < s) begin
            h = s - d;
            h2 = (h * h) >> FRAC;
            diff = longint'(held_radius) - longint'(q.rb);
            p = longint'(d * d) + longint'(2 * d * s) - 3 * diff * diff;
            neg = p < 0;
            m = longint'(neg ? -p : p) >> FRAC;
            n = h2 * m;
            den = 12 * d;
            a = n / den;
            r = n % den;
            if (a >= (64'd1 << 40)) begin
               cap = 64'd1 << 40;
            end else begin
               x = a * 51472 + (r * 51472) / den;
               cap = (x + (64'd1 << 13)) >> 14;
               if (cap > (64'd1 << 40)) cap = 64'd1 << 40;
            end
            if (neg) run_volume = clamp40(run_volume + longint'(cap));
            else run_volume = clamp40(run_volume - longint'(cap));
         end
      end
      if (q.last) begin
         emits = 1;
         if (run_volume > floor_vol)
            vol = (run_volume > 64'sd4294967295) ? OUT_MAX : run_volume[31:0];
         else
            vol = floor_vol[31:0];
      end
   endtask

   task automatic add_req(input bit first, input bit last, input bit valid,
                          input int rmax, input int rmin, input int rb, input int distance,
                          input bit pause);
      atom_req_type q;
      q.first = first;
      q.last = last;
      q.valid = valid;
      q.pause = pause;
      q.rmax = LEN_W'(rmax);
      q.rmin = LEN_W'(rmin);
      q.rb = LEN_W'(rb);
      q.distance = LEN_W'(distance);
      pending_reqs.push_back(q);
   endtask

   // One well-formed atom with random content: 1 to 6 neighbors, or a single no-bond request.
   task automatic add_atom(input bit pause);
      int ra, rm, nb, rbv, s, dv;
      if ($urandom_range(0, 7) == 0) ra = $urandom_range(0, 65535);
      else ra = $urandom_range(2048, 16384);
      if ($urandom_range(0, 5) == 0) rm = $urandom_range(0, 65535);
      else rm = $urandom_range(0, ra);
      nb = $urandom_range(1, 6);
      atom_count++;
      if ($urandom_range(0, 9) == 0) begin
         add_req(1, 1, 0, ra, rm, $urandom_range(0, 65535), $urandom_range(0, 65535), pause);
         return;
      end
      for (int i = 0; i < nb; i++) begin
         rbv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(1024, 16384);
         s = ra + rbv;
         case ($urandom_range(0, 9))
            0: dv = 0;
            1: dv = (s > 65535) ? 65535 : s;
            2: dv = $urandom_range(0, 65535);
            default: dv = (s > 1) ? $urandom_range(1, (s - 1 > 65535) ? 65535 : s - 1) : 0;
         endcase
         add_req(i == 0, i == nb - 1, 1,
                 (i == 0) ? ra : $urandom_range(0, 65535),
                 (i == 0) ? rm : $urandom_range(0, 65535), rbv, dv, pause && i == 0);
      end
   endtask

   // Driver: presents queued requests, with random gaps and a drain pause.
   always @(posedge clock) begin
      bit         accepted;
      bit         emits;
      bit [31:0]  vol;
      accepted = push && !full;
      if (reset) begin
         push <= 0;
      end else begin
         if (accepted) begin
            accepted_reqs++;
            predict_volume(cur_req, emits, vol);
            if (emits) volume_queue.push_back(vol);
         end
         if (!push || accepted) begin
            if (!quiet && push_gap == 0 && $urandom_range(0, 11) == 0)
               push_gap = $urandom_range(1, 15);
            if (push_gap > 0) begin
               push_gap--;
               push <= 0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].pause && volume_queue.size() != 0)) begin
               cur_req = pending_reqs.pop_front();
               req_first_of_atom <= cur_req.first;
               req_last_of_atom <= cur_req.last;
               req_neighbour_valid <= cur_req.valid;
               req_atom_max_radius <= cur_req.rmax;
               req_atom_min_radius <= cur_req.rmin;
               req_neighbour_radius <= cur_req.rb;
               req_neighbour_distance <= cur_req.distance;
               push <= 1;
            end else begin
               push <= 0;
            end
         end
      end
   end

   // Monitor: checks each popped volume against the oldest prediction.
   always @(posedge clock) begin
      bit [31:0] want;
      if (reset) begin
         pop <= 0;
      end else begin
         if (pop && !empty) begin
            if (volume_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected volume, expected none, actual %h",
                        $time, rsp_volume);
            end else begin
               want = volume_queue.pop_front();
               checked_volumes++;
               if (rsp_volume !== want) begin
                  errors++;
                  $display("%0t: volume mismatch, expected %h, actual %h",
                           $time, want, rsp_volume);
               end
            end
         end
         if (!quiet && pop_gap == 0 && $urandom_range(0, 11) == 0)
            pop_gap = $urandom_range(1, 15);
         if (pop_gap > 0) begin
            pop_gap--;
            pop <= 0;
         end else begin
            pop <= 1;
         end
      end
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset = 1;
      push = 0;
      pop = 0;
      req_first_of_atom = 0;
      req_last_of_atom = 0;
      req_neighbour_valid = 0;
      req_atom_max_radius = 0;
      req_atom_min_radius = 0;
      req_neighbour_radius = 0;
      req_neighbour_distance = 0;

      // Directed: last without any first, no-bond atom, skips and extremes.
      add_req(0, 1, 1, 65535, 65535, 4096, 4096, 0);
      add_req(1, 1, 0, 6144, 2048, 0, 0, 0);
      add_req(1, 0, 1, 6144, 2048, 4096, 0, 0);
      add_req(0, 0, 1, 0, 0, 4096, 10240, 0);
      add_req(0, 0, 1, 0, 0, 4096, 12000, 0);
      add_req(0, 1, 1, 0, 0, 4096, 8000, 0);
      add_req(0, 1, 1, 65535, 65535, 4096, 6000, 0);
      add_req(1, 1, 1, 65535, 0, 65535, 1, 0);
      add_req(1, 1, 1, 65535, 65535, 65535, 65535, 0);
      add_req(1, 0, 1, 40000, 0, 1000, 100, 0);
      add_req(0, 1, 1, 0, 0, 1000, 200, 0);
      add_req(1, 0, 1, 8192, 65535, 4096, 6000, 0);
      add_req(0, 1, 1, 0, 0, 4096, 6000, 0);
      add_req(1, 0, 1, 8192, 8000, 8192, 1, 0);
      add_req(0, 1, 1, 0, 0, 8192, 4096, 0);
      add_req(1, 1, 1, 0, 0, 0, 0, 0);
      add_req(1, 1, 1, 65535, 65535, 0, 65534, 0);
      atom_count += 12;

      // Random atoms and stray requests, a few atoms waiting for the block to drain first.
      while (pending_reqs.size() < 900) begin
         add_atom($urandom_range(0, 99) == 0);
         if ($urandom_range(0, 29) == 0) begin
            add_req($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
         end
      end
      add_atom(1);

      repeat (7) @(posedge clock);
      reset <= 0;

      wait (pending_reqs.size() < 120);
      quiet = 1;
      wait (pending_reqs.size() == 0 && !push);
      wait (volume_queue.size() == 0);
      repeat (200) @(posedge clock);

      $display("Covered %0d requests over about %0d atoms, %0d volumes checked.",
               accepted_reqs, atom_count, checked_volumes);
      if (errors == 0 && volume_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/avo_pkg.sv
rtl/avo_fifo.sv
rtl/avo_front.sv
rtl/avo_back.sv
rtl/atom_volume_overlap.sv
dv/atom_volume_overlap_test.sv
